// File: rtl/tdmfd_pkg.sv
// ----------------------------------------------------------------------------
// tdmfd_pkg
// Shared constants and types of the TDM frame deserializer.
// ----------------------------------------------------------------------------
package tdmfd_pkg;

    localparam int MAX_FRAME_BITS = 512;
    localparam int MAX_CHANNELS   = 8;
    localparam int WORD_BITS      = 64;

    localparam int ADDR_W = $clog2(MAX_FRAME_BITS);
    localparam int CNT_W  = $clog2(MAX_FRAME_BITS + 1);
    localparam int POS_W  = $clog2(WORD_BITS);
    localparam int CH_W   = 3;
    localparam int NCH_W  = 4;
    localparam int ND_W   = 7;

    localparam logic [1:0] REG_CHANNELS  = 2'd0;
    localparam logic [1:0] REG_DATA_BITS = 2'd1;
    localparam logic [1:0] REG_LSB_FIRST = 2'd2;

    localparam logic [NCH_W-1:0] CHANNELS_RESET  = 4'd1;
    localparam logic [ND_W-1:0]  DATA_BITS_RESET = 7'd16;

    typedef enum logic [1:0] {
        KIND_OK       = 2'd0,
        KIND_LENGTH   = 2'd1,
        KIND_SHORT    = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_RD,
        S_ACC,
        S_EMIT,
        S_ERR,
        S_DONE
    } t_state;

endpackage

// File: rtl/tdm_frame_deserializer_top.sv
// ----------------------------------------------------------------------------
// tdm_frame_deserializer_top
// Buffers sampled command/status bits per frame and unpacks channel words at
// each closing frame-sync edge.
// ----------------------------------------------------------------------------
// channel  | handshake                    | payload
// input    | i_in_valid / o_in_ready      | command, status, sync bit
// output   | o_out_valid / i_out_ready    | words, channel, kind, last
// config   | i_cfg_we                     | i_cfg_index, i_cfg_data
//
// a bit that does not close a frame is written to the buffer while a frame is open and
// the buffer has room; a closing edge runs 10 divider steps and a check, then one
// buffer read and one accumulate per data bit of each channel; stalls hold results
// a length or slot-size error follows the check, an overflow skips the divider
// synchronous active-low reset, the bit buffer itself is not cleared
// ----------------------------------------------------------------------------
module tdm_frame_deserializer_top
    import tdmfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [ND_W-1:0]      i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command_bit,
    input  logic                 i_status_bit,
    input  logic                 i_sync_bit,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [WORD_BITS-1:0] o_command_word,
    output logic [WORD_BITS-1:0] o_status_word,
    output logic [CH_W-1:0]      o_channel_number,
    output logic [1:0]           o_result_kind,
    output logic                 o_last_of_frame
);

    t_state r_state, n_state;

    logic [NCH_W-1:0] r_cfg_nch;
    logic [ND_W-1:0]  r_cfg_nd;
    logic             r_cfg_lsb;

    logic             r_prev_sync;
    logic             r_in_frame;
    logic [CNT_W-1:0] r_count;
    logic             r_overflow;
    logic [1:0]       r_pending;

    logic [1:0]       r_mem [MAX_FRAME_BITS];
    logic [1:0]       r_rd_data;

    logic [CNT_W-1:0] r_quo;
    logic [NCH_W-1:0] r_rem;
    logic [3:0]       r_div_cnt;

    logic [CNT_W-1:0] r_base;
    logic [ND_W-1:0]  r_k;
    logic [POS_W-1:0] r_pos;
    logic [CH_W-1:0]  r_chan;
    logic [WORD_BITS-1:0] r_cmd_acc;
    logic [WORD_BITS-1:0] r_sts_acc;
    t_kind            r_err_kind;

    logic             r_out_valid;
    logic [WORD_BITS-1:0] r_out_cmd;
    logic [WORD_BITS-1:0] r_out_sts;
    logic [CH_W-1:0]  r_out_chan;
    t_kind            r_out_kind;
    logic             r_out_last;

    logic [NCH_W-1:0] w_nch;
    logic [ND_W-1:0]  w_nd;
    logic [POS_W-1:0] w_pos_init;
    logic             w_accept;
    logic             w_edge;
    logic             w_close;
    logic             w_out_load;
    logic             w_last_chan;
    logic             w_bit_done;
    logic [NCH_W:0]   w_trial;
    logic             w_trial_ge;
    logic [ADDR_W-1:0] w_rd_addr;
    logic             w_mem_we;
    logic [ADDR_W-1:0] w_mem_waddr;
    logic [1:0]       w_mem_wdata;

    // clamped configuration
    always_comb begin
        if (r_cfg_nch == '0) begin
            w_nch = NCH_W'(1);
        end else if (r_cfg_nch > NCH_W'(MAX_CHANNELS)) begin
            w_nch = NCH_W'(MAX_CHANNELS);
        end else begin
            w_nch = r_cfg_nch;
        end
        if (r_cfg_nd == '0) begin
            w_nd = ND_W'(1);
        end else if (r_cfg_nd > ND_W'(WORD_BITS)) begin
            w_nd = ND_W'(WORD_BITS);
        end else begin
            w_nd = r_cfg_nd;
        end
    end

    assign w_pos_init  = r_cfg_lsb ? '0 : POS_W'(w_nd - ND_W'(1));
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_edge      = r_prev_sync && !i_sync_bit;
    assign w_close     = w_accept && w_edge && r_in_frame;
    assign w_out_load  = !r_out_valid || i_out_ready;
    assign w_last_chan = ({1'b0, r_chan} == NCH_W'(w_nch - NCH_W'(1)));
    assign w_bit_done  = (r_k == ND_W'(w_nd - ND_W'(1)));
    assign w_trial     = {r_rem, r_quo[CNT_W-1]};
    assign w_trial_ge  = (w_trial >= {1'b0, w_nch});
    assign w_rd_addr   = ADDR_W'(r_base + CNT_W'(r_k));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_close) begin
                    n_state = r_overflow ? S_ERR : S_DIV;
                end
            end
            S_DIV: begin
                if (r_div_cnt == 4'(CNT_W - 1)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_rem != '0 || r_quo < CNT_W'(w_nd)) begin
                    n_state = S_ERR;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_state = w_bit_done ? S_EMIT : S_RD;
            end
            S_EMIT: begin
                if (w_out_load) begin
                    n_state = w_last_chan ? S_DONE : S_RD;
                end
            end
            S_ERR: begin
                if (w_out_load) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready  = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_count[ADDR_W-1:0];
        w_mem_wdata = {i_status_bit, i_command_bit};
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept && w_edge && !r_in_frame) begin
                    w_mem_we    = 1'b1;
                    w_mem_waddr = '0;
                end else if (w_accept && !w_edge && r_in_frame &&
                             r_count < CNT_W'(MAX_FRAME_BITS)) begin
                    w_mem_we = 1'b1;
                end
            end
            S_DONE: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = '0;
                w_mem_wdata = r_pending;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // bit buffer
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (r_state == S_RD) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_nch   <= CHANNELS_RESET;
            r_cfg_nd    <= DATA_BITS_RESET;
            r_cfg_lsb   <= 1'b0;
            r_prev_sync <= 1'b0;
            r_in_frame  <= 1'b0;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CHANNELS:  r_cfg_nch <= i_cfg_data[NCH_W-1:0];
                    REG_DATA_BITS: r_cfg_nd  <= i_cfg_data;
                    REG_LSB_FIRST: r_cfg_lsb <= i_cfg_data[0];
                    default: begin
                        r_cfg_lsb <= r_cfg_lsb;
                    end
                endcase
            end
            if (w_accept) begin
                r_prev_sync <= i_sync_bit;
                if (w_edge && !r_in_frame) begin
                    r_in_frame <= 1'b1;
                    r_overflow <= 1'b0;
                    r_count    <= CNT_W'(1);
                end else if (!w_edge && r_in_frame) begin
                    if (r_count < CNT_W'(MAX_FRAME_BITS)) begin
                        r_count <= r_count + CNT_W'(1);
                    end else begin
                        r_overflow <= 1'b1;
                    end
                end
            end
            if (r_state == S_DONE) begin
                r_overflow <= 1'b0;
                r_count    <= CNT_W'(1);
            end
            if (((r_state == S_EMIT) || (r_state == S_ERR)) && w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_close) begin
                    r_pending  <= {i_status_bit, i_command_bit};
                    r_quo      <= r_count;
                    r_rem      <= '0;
                    r_div_cnt  <= '0;
                    r_err_kind <= KIND_OVERFLOW;
                end
            end
            S_DIV: begin
                r_quo     <= {r_quo[CNT_W-2:0], w_trial_ge};
                r_rem     <= w_trial_ge ? NCH_W'(w_trial - {1'b0, w_nch})
                                        : NCH_W'(w_trial);
                r_div_cnt <= r_div_cnt + 4'd1;
            end
            S_CHECK: begin
                r_err_kind <= (r_rem != '0) ? KIND_LENGTH : KIND_SHORT;
                r_base     <= '0;
                r_k        <= '0;
                r_pos      <= w_pos_init;
                r_chan     <= '0;
                r_cmd_acc  <= '0;
                r_sts_acc  <= '0;
            end
            S_ACC: begin
                r_cmd_acc[r_pos] <= r_rd_data[0];
                r_sts_acc[r_pos] <= r_rd_data[1];
                if (!w_bit_done) begin
                    r_k   <= r_k + ND_W'(1);
                    r_pos <= r_cfg_lsb ? r_pos + POS_W'(1) : r_pos - POS_W'(1);
                end
            end
            S_EMIT: begin
                if (w_out_load) begin
                    r_out_cmd  <= r_cmd_acc;
                    r_out_sts  <= r_sts_acc;
                    r_out_chan <= r_chan;
                    r_out_kind <= KIND_OK;
                    r_out_last <= w_last_chan;
                    r_chan     <= r_chan + CH_W'(1);
                    r_base     <= r_base + r_quo;
                    r_k        <= '0;
                    r_pos      <= w_pos_init;
                    r_cmd_acc  <= '0;
                    r_sts_acc  <= '0;
                end
            end
            S_ERR: begin
                if (w_out_load) begin
                    r_out_cmd  <= '0;
                    r_out_sts  <= '0;
                    r_out_chan <= '0;
                    r_out_kind <= r_err_kind;
                    r_out_last <= 1'b1;
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_command_word   = r_out_cmd;
    assign o_status_word    = r_out_sts;
    assign o_channel_number = r_out_chan;
    assign o_result_kind    = r_out_kind;
    assign o_last_of_frame  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_FRAME_BITS))
        else $error("bit count beyond buffer size");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_count == CNT_W'(MAX_FRAME_BITS)))
        else $error("overflow flagged with buffer not full");

    a_done_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_count == CNT_W'(1) && !r_overflow))
        else $error("next frame not started after close");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_load && w_last_chan) |=>
        (r_state == S_DONE && r_out_last))
        else $error("last channel did not end the frame");

endmodule

// File: bench/tdm_frame_deserializer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tdm_frame_deserializer_top_tb
// Sends sampled command/status/sync bits through the input handshake and
// checks every channel word against a frame predictor kept in a scoreboard.
// A directed opening is followed by phases of random frames under changing
// register settings, with random idling on both sides and one long output
// hold-off.
// ----------------------------------------------------------------------------
module tdm_frame_deserializer_top_tb;
    import tdmfd_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 1200;
    localparam int unsigned HOLD_CYCLES   = 2500;
    localparam int unsigned LIMIT_CYCLES  = 2_000_000;
    localparam int unsigned RANDOM_ITEMS  = 40;

    typedef struct packed {
        logic [WORD_BITS-1:0] cmd;
        logic [WORD_BITS-1:0] sts;
        logic [CH_W-1:0]      chan;
        t_kind                kind;
        logic                 last;
    } t_chan_word;

    typedef enum {FR_GOOD, FR_LENGTH, FR_SHORT, FR_OVERFLOW, FR_NOISE, FR_MIXED} t_frame_shape;

    class t_frame_scoreboard;
        bit               cmd_buf [MAX_FRAME_BITS];
        bit               sts_buf [MAX_FRAME_BITS];
        bit               prev_sync;
        bit               synced;
        bit               overflow_seen;
        int unsigned      fill;
        logic [NCH_W-1:0] nch_reg = CHANNELS_RESET;
        logic [ND_W-1:0]  nd_reg  = DATA_BITS_RESET;
        bit               lsb_reg;
        t_chan_word       expected_words [$];
        int unsigned      errors;
        int unsigned      results_done;

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void add_expected(t_chan_word w);
            expected_words.insert(expected_words.size(), w);
        endfunction

        function void set_reg(logic [1:0] idx, logic [ND_W-1:0] val);
            case (idx)
                REG_CHANNELS:  nch_reg = val[NCH_W-1:0];
                REG_DATA_BITS: nd_reg  = val;
                REG_LSB_FIRST: lsb_reg = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_channels();
            int unsigned n;
            n = 32'(nch_reg);
            if (n == 0)
                return 1;
            if (n > MAX_CHANNELS)
                return MAX_CHANNELS;
            return n;
        endfunction

        function int unsigned eff_data_bits();
            int unsigned n;
            n = 32'(nd_reg);
            if (n == 0)
                return 1;
            if (n > WORD_BITS)
                return WORD_BITS;
            return n;
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction

        function void unpack_frame();
            int unsigned nch;
            int unsigned nd;
            int unsigned per;
            int unsigned base;
            int unsigned pos;
            int unsigned c;
            int unsigned k;
            t_chan_word  w;
            nch = eff_channels();
            nd  = eff_data_bits();
            w = '0;
            w.last = 1'b1;
            if (overflow_seen) begin
                w.kind = KIND_OVERFLOW;
                add_expected(w);
                return;
            end
            if (fill % nch != 0) begin
                w.kind = KIND_LENGTH;
                add_expected(w);
                return;
            end
            per = fill / nch;
            if (per < nd) begin
                w.kind = KIND_SHORT;
                add_expected(w);
                return;
            end
            for (c = 0; c < nch; c++) begin
                w = '0;
                w.kind = KIND_OK;
                w.chan = c[CH_W-1:0];
                w.last = (c == nch - 1);
                base = c * per;
                for (k = 0; k < nd; k++) begin
                    pos = lsb_reg ? k : nd - 1 - k;
                    w.cmd[POS_W'(pos)] = cmd_buf[ADDR_W'(base + k)];
                    w.sts[POS_W'(pos)] = sts_buf[ADDR_W'(base + k)];
                end
                add_expected(w);
            end
        endfunction

        function void take_bit(bit c, bit s, bit y);
            if (prev_sync && !y) begin
                if (synced)
                    unpack_frame();
                synced        = 1'b1;
                overflow_seen = 1'b0;
                cmd_buf[0]    = c;
                sts_buf[0]    = s;
                fill          = 1;
            end else if (synced) begin
                if (fill < MAX_FRAME_BITS) begin
                    cmd_buf[ADDR_W'(fill)] = c;
                    sts_buf[ADDR_W'(fill)] = s;
                    fill++;
                end else begin
                    overflow_seen = 1'b1;
                end
            end
            prev_sync = y;
        endfunction

        task check_word(logic [WORD_BITS-1:0] cmd, logic [WORD_BITS-1:0] sts,
                        logic [CH_W-1:0] chan, logic [1:0] kind, logic last);
            t_chan_word w;
            results_done++;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected result, channel %0d kind %0d", chan, kind));
                return;
            end
            w = expected_words.pop_front();
            if (cmd !== w.cmd)
                report($sformatf("channel %0d command word %h, predicted %h",
                                 w.chan, cmd, w.cmd));
            if (sts !== w.sts)
                report($sformatf("channel %0d status word %h, predicted %h",
                                 w.chan, sts, w.sts));
            if (chan !== w.chan)
                report($sformatf("channel number %0d, predicted %0d", chan, w.chan));
            if (kind !== w.kind)
                report($sformatf("channel %0d kind %0d, predicted %0d", w.chan, kind, w.kind));
            if (last !== w.last)
                report($sformatf("channel %0d last flag %b, predicted %b",
                                 w.chan, last, w.last));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_index;
    logic [ND_W-1:0]      i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_command_bit;
    logic                 i_status_bit;
    logic                 i_sync_bit;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [WORD_BITS-1:0] o_command_word;
    logic [WORD_BITS-1:0] o_status_word;
    logic [CH_W-1:0]      o_channel_number;
    logic [1:0]           o_result_kind;
    logic                 o_last_of_frame;

    t_frame_scoreboard sb = new;
    int unsigned       items_sent;
    bit                steady;
    bit                hold_request;
    bit                frame_open;

    tdm_frame_deserializer_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command_bit    (i_command_bit),
        .i_status_bit     (i_status_bit),
        .i_sync_bit       (i_sync_bit),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_command_word   (o_command_word),
        .o_status_word    (o_status_word),
        .o_channel_number (o_channel_number),
        .o_result_kind    (o_result_kind),
        .o_last_of_frame  (o_last_of_frame)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_bit(bit c, bit s, bit y);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command_bit <= c;
        i_status_bit  <= s;
        i_sync_bit    <= y;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.take_bit(c, s, y);
        items_sent++;
    endtask

    task automatic send_pattern(logic [15:0] cmd, logic [15:0] sts, int unsigned len);
        int unsigned i;
        for (i = 0; i < len; i++)
            send_bit(cmd[4'(i)], sts[4'(i)], i == len - 1);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [NCH_W-1:0] nch, logic [ND_W-1:0] nd, bit lsb);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_CHANNELS;
        i_cfg_data  <= ND_W'(nch);
        @(posedge i_clk);
        sb.set_reg(REG_CHANNELS, ND_W'(nch));
        i_cfg_index <= REG_DATA_BITS;
        i_cfg_data  <= nd;
        @(posedge i_clk);
        sb.set_reg(REG_DATA_BITS, nd);
        i_cfg_index <= REG_LSB_FIRST;
        i_cfg_data  <= ND_W'(lsb);
        @(posedge i_clk);
        sb.set_reg(REG_LSB_FIRST, ND_W'(lsb));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_frame(t_frame_shape shape);
        int unsigned nch;
        int unsigned nd;
        int unsigned per;
        int unsigned len;
        int unsigned sync_tail;
        int unsigned first;
        int unsigned i;
        bit          y;
        nch = sb.eff_channels();
        nd  = sb.eff_data_bits();
        case (shape)
            FR_GOOD: begin
                per = nd + $urandom_range(0, 2);
                if (nch * per > MAX_FRAME_BITS)
                    per = MAX_FRAME_BITS / nch;
                len = nch * per;
            end
            FR_LENGTH: begin
                per = $urandom_range(1, 6);
                len = nch * per + ((nch > 1) ? $urandom_range(1, nch - 1) : 0);
            end
            FR_SHORT: begin
                per = (nd > 1) ? $urandom_range(1, nd - 1) : nd;
                len = nch * per;
            end
            FR_OVERFLOW: len = MAX_FRAME_BITS + $urandom_range(1, 6);
            default:     len = $urandom_range(2, 24);
        endcase
        if (len < 2)
            len = 2;
        sync_tail = (len > 3 && $urandom_range(0, 4) == 0) ? 2 : 1;
        // the closing bit of the previous phase already opened this frame
        first = frame_open ? 1 : 0;
        frame_open = 1'b0;
        for (i = first; i < len; i++) begin
            if (shape == FR_NOISE)
                y = 1'($urandom_range(0, 1));
            else
                y = (i >= len - sync_tail);
            send_bit(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), y);
        end
    endtask

    task automatic run_phase(logic [NCH_W-1:0] nch, logic [ND_W-1:0] nd, bit lsb,
                             int unsigned frames, t_frame_shape shape, bit hold);
        int unsigned  f;
        int unsigned  r;
        t_frame_shape pick;
        write_regs(nch, nd, lsb);
        steady = hold ? 1'b0 : ($urandom_range(0, 4) == 0);
        if (hold)
            hold_request = 1'b1;
        for (f = 0; f < frames; f++) begin
            pick = shape;
            if (shape == FR_MIXED) begin
                r = $urandom_range(0, 99);
                pick = (r < 65) ? FR_GOOD : (r < 77) ? FR_LENGTH : (r < 89) ? FR_SHORT :
                       FR_NOISE;
            end
            send_frame(pick);
        end
        send_bit(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
        frame_open = 1'b1;
        settle();
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin
        int unsigned wait_left;
        wait_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                sb.check_word(o_command_word, o_status_word, o_channel_number,
                              o_result_kind, o_last_of_frame);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (wait_left != 0) begin
                i_out_ready <= 1'b0;
                wait_left--;
            end else begin
                i_out_ready <= 1'b1;
                wait_left = pick_gap();
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int unsigned      item_mark;
        int unsigned      r;
        logic [NCH_W-1:0] nch;
        logic [ND_W-1:0]  nd;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_CHANNELS;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_command_bit <= 1'b0;
        i_status_bit  <= 1'b0;
        i_sync_bit    <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening: bits before the first edge, good, odd-length, short
        write_regs(4'd2, 7'd3, 1'b0);
        send_bit(1'b1, 1'b1, 1'b0);
        send_bit(1'b0, 1'b0, 1'b1);
        send_pattern(16'h0029, 16'h0016, 6);
        send_pattern(16'h001f, 16'h0000, 5);
        send_pattern(16'h000f, 16'h000f, 4);
        send_pattern(16'h00a5, 16'h005a, 8);
        send_bit(1'b1, 1'b1, 1'b0);
        frame_open = 1'b1;
        settle();

        // register extremes, clamped values and output back-pressure
        run_phase(4'd15, 7'd2, 1'b0, 1, FR_GOOD, 1'b0);
        run_phase(4'd1, 7'd127, 1'b1, 1, FR_GOOD, 1'b0);
        run_phase(4'd0, 7'd0, 1'b1, 4, FR_MIXED, 1'b0);
        run_phase(4'd8, 7'd2, 1'b0, 2, FR_GOOD, 1'b1);

        item_mark = items_sent;
        while (items_sent - item_mark < RANDOM_ITEMS) begin
            r = $urandom_range(0, 19);
            nch = (r < 14) ? NCH_W'($urandom_range(1, 4)) : (r < 16) ? 4'd0 :
                  (r < 18) ? NCH_W'($urandom_range(9, 15)) : NCH_W'($urandom_range(5, 8));
            r = $urandom_range(0, 19);
            nd = (r < 15) ? ND_W'($urandom_range(1, 8)) :
                 (r < 18) ? ND_W'($urandom_range(9, 12)) : 7'd0;
            run_phase(nch, nd, 1'($urandom_range(0, 1)), $urandom_range(2, 3), FR_MIXED, 1'b0);
        end

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tdmfd_pkg.sv
rtl/tdm_frame_deserializer_top.sv
bench/tdm_frame_deserializer_top_tb.sv
